### rtl/rid_pkg.sv
// Shared types and codes for the instruction decoder.
package rid_pkg;

	localparam int unsigned InstrW = 16;

	// ALU control codes.
	typedef enum logic [3:0] {
		ALU_ADD   = 4'd0,
		ALU_SUB   = 4'd1,
		ALU_CMP   = 4'd2,
		ALU_AND   = 4'd3,
		ALU_OR    = 4'd4,
		ALU_XOR   = 4'd5,
		ALU_MOV   = 4'd6,
		ALU_LSH   = 4'd7,
		ALU_ASH   = 4'd8,
		ALU_LOAD  = 4'd9,
		ALU_STOR  = 4'd10,
		ALU_BCOND = 4'd11,
		ALU_JCOND = 4'd12,
		ALU_JAL   = 4'd13
	} alu_op_t;

	// Major opcode / extension codes of the arithmetic family.
	localparam logic [3:0] AR_ADD = 4'b0101;
	localparam logic [3:0] AR_SUB = 4'b1001;
	localparam logic [3:0] AR_CMP = 4'b1011;
	localparam logic [3:0] AR_AND = 4'b0001;
	localparam logic [3:0] AR_OR  = 4'b0010;
	localparam logic [3:0] AR_XOR = 4'b0011;
	localparam logic [3:0] AR_MOV = 4'b1101;

	// Other major opcodes.
	localparam logic [3:0] OPC_REG   = 4'b0000;
	localparam logic [3:0] OPC_SHIFT = 4'b1000;
	localparam logic [3:0] OPC_LUI   = 4'b1111;
	localparam logic [3:0] OPC_MEM   = 4'b0100;
	localparam logic [3:0] OPC_BCOND = 4'b1100;

	// Shift family extensions.
	localparam logic [3:0] EXT_LSH  = 4'b0100;
	localparam logic [3:0] EXT_LSHI = 4'b0000;
	localparam logic [3:0] EXT_ASH  = 4'b0110;
	localparam logic [3:0] EXT_ASHI = 4'b0001;

	// Memory / jump family extensions.
	localparam logic [3:0] EXT_LOAD  = 4'b0000;
	localparam logic [3:0] EXT_STOR  = 4'b0100;
	localparam logic [3:0] EXT_JCOND = 4'b1100;
	localparam logic [3:0] EXT_JAL   = 4'b1000;

	// Decoded control bundle.
	typedef struct packed {
		alu_op_t     alu_op;
		logic        use_immediate;
		logic [3:0]  dest_or_cond;
		logic [3:0]  source_reg;
		logic [7:0]  immediate_value;
		logic        reads_memory;
		logic        writes_memory;
		logic        writes_register;
		logic        changes_pc;
		logic        is_nop;
		logic        is_illegal;
	} ctrl_t;

endpackage

### rtl/risc_instruction_decoder.sv
// Top level of the instruction decoder: input register, decode, result register.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------
//   in      | input     | in_valid / in_stall | instruction[15:0]
//   out     | output    | out_valid/out_stall | alu_op .. is_illegal (control bundle)
//
// One instruction per cycle while out is not stalled; each word passes the input
// register, then the decode logic, then the result register. The decode is a single
// pass of case logic between the two registers.
// Reset (arst_n low) empties both stages; payload registers are not reset.
// A stall on out holds the result; the input register still takes a transfer
// while the result waits, and in_stall rises only when both stages are full.
module risc_instruction_decoder (
	input  logic        clk,
	input  logic        arst_n,
	// Input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] instruction,
	// Result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  alu_op,
	output logic        use_immediate,
	output logic [3:0]  dest_or_cond,
	output logic [3:0]  source_reg,
	output logic [7:0]  immediate_value,
	output logic        reads_memory,
	output logic        writes_memory,
	output logic        writes_register,
	output logic        changes_pc,
	output logic        is_nop,
	output logic        is_illegal
);

	// Stage 1: registered instruction word.
	logic                       valid_s1;
	logic [rid_pkg::InstrW-1:0] instr_s1;
	// Stage 2: registered control bundle.
	logic                       valid_s2;
	rid_pkg::ctrl_t             ctrl_s2;
	rid_pkg::ctrl_t             ctrl_dec;

	logic adv_s2;   // stage 2 loads this cycle
	logic adv_s1;   // stage 1 loads this cycle

	// Stage 2 can load when empty or when its result leaves this cycle.
	assign adv_s2   = !valid_s2 || !out_stall;
	// Stage 1 can load when empty or when its item moves to stage 2.
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			instr_s1 <= instruction;
		end
	end

	rid_decode u_decode (
		.instruction (instr_s1),
		.ctrl        (ctrl_dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// Hold the result while stalled; advance only with a real item.
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			ctrl_s2 <= ctrl_dec;
		end
	end

	assign out_valid       = valid_s2;
	assign alu_op          = ctrl_s2.alu_op;
	assign use_immediate   = ctrl_s2.use_immediate;
	assign dest_or_cond    = ctrl_s2.dest_or_cond;
	assign source_reg      = ctrl_s2.source_reg;
	assign immediate_value = ctrl_s2.immediate_value;
	assign reads_memory    = ctrl_s2.reads_memory;
	assign writes_memory   = ctrl_s2.writes_memory;
	assign writes_register = ctrl_s2.writes_register;
	assign changes_pc      = ctrl_s2.changes_pc;
	assign is_nop          = ctrl_s2.is_nop;
	assign is_illegal      = ctrl_s2.is_illegal;

endmodule

### rtl/rid_decode.sv
// Combinational decode of one instruction word into a control bundle.
module rid_decode (
	input  logic [rid_pkg::InstrW-1:0] instruction,
	output rid_pkg::ctrl_t             ctrl
);

	logic [3:0]       opc;
	logic [3:0]       ext;
	logic             nop;
	logic             legal;
	logic             imm;
	logic             rd;
	logic             wr;
	rid_pkg::alu_op_t alu;

	assign opc = instruction[15:12];
	assign ext = instruction[7:4];
	assign nop = (instruction == '0);

	always_comb begin
		alu   = rid_pkg::ALU_ADD;
		imm   = 1'b0;
		rd    = 1'b0;
		wr    = 1'b0;
		legal = 1'b1;
		unique case (opc)
			rid_pkg::OPC_REG: begin
				unique case (ext)
					rid_pkg::AR_ADD: alu = rid_pkg::ALU_ADD;
					rid_pkg::AR_SUB: alu = rid_pkg::ALU_SUB;
					rid_pkg::AR_CMP: alu = rid_pkg::ALU_CMP;
					rid_pkg::AR_AND: alu = rid_pkg::ALU_AND;
					rid_pkg::AR_OR:  alu = rid_pkg::ALU_OR;
					rid_pkg::AR_XOR: alu = rid_pkg::ALU_XOR;
					rid_pkg::AR_MOV: alu = rid_pkg::ALU_MOV;
					default:         legal = 1'b0;
				endcase
			end
			rid_pkg::AR_ADD: begin alu = rid_pkg::ALU_ADD; imm = 1'b1; end
			rid_pkg::AR_SUB: begin alu = rid_pkg::ALU_SUB; imm = 1'b1; end
			rid_pkg::AR_CMP: begin alu = rid_pkg::ALU_CMP; imm = 1'b1; end
			rid_pkg::AR_AND: begin alu = rid_pkg::ALU_AND; imm = 1'b1; end
			rid_pkg::AR_OR:  begin alu = rid_pkg::ALU_OR;  imm = 1'b1; end
			rid_pkg::AR_XOR: begin alu = rid_pkg::ALU_XOR; imm = 1'b1; end
			rid_pkg::AR_MOV: begin alu = rid_pkg::ALU_MOV; imm = 1'b1; end
			rid_pkg::OPC_SHIFT: begin
				unique case (ext)
					rid_pkg::EXT_LSH:  alu = rid_pkg::ALU_LSH;
					rid_pkg::EXT_LSHI: begin alu = rid_pkg::ALU_LSH; imm = 1'b1; end
					rid_pkg::EXT_ASH:  alu = rid_pkg::ALU_ASH;
					rid_pkg::EXT_ASHI: begin alu = rid_pkg::ALU_ASH; imm = 1'b1; end
					default:           legal = 1'b0;
				endcase
			end
			rid_pkg::OPC_LUI: begin alu = rid_pkg::ALU_LOAD; imm = 1'b1; end
			rid_pkg::OPC_MEM: begin
				unique case (ext)
					rid_pkg::EXT_LOAD:  begin alu = rid_pkg::ALU_LOAD; rd = 1'b1; end
					rid_pkg::EXT_STOR:  begin alu = rid_pkg::ALU_STOR; wr = 1'b1; end
					rid_pkg::EXT_JCOND: alu = rid_pkg::ALU_JCOND;
					rid_pkg::EXT_JAL:   alu = rid_pkg::ALU_JAL;
					default:            legal = 1'b0;
				endcase
			end
			rid_pkg::OPC_BCOND: alu = rid_pkg::ALU_BCOND;
			default:            legal = 1'b0;
		endcase
		if (nop) begin
			legal = 1'b0;
		end
	end

	always_comb begin
		ctrl                 = '0;
		ctrl.dest_or_cond    = instruction[11:8];
		ctrl.source_reg      = instruction[3:0];
		ctrl.immediate_value = instruction[7:0];
		ctrl.is_nop          = nop;
		ctrl.is_illegal      = !nop && !legal;
		ctrl.alu_op          = rid_pkg::ALU_ADD;
		if (legal) begin
			ctrl.alu_op          = alu;
			ctrl.use_immediate   = imm;
			ctrl.reads_memory    = rd;
			ctrl.writes_memory   = wr;
			ctrl.writes_register = !(alu == rid_pkg::ALU_CMP || alu == rid_pkg::ALU_STOR ||
				alu == rid_pkg::ALU_BCOND || alu == rid_pkg::ALU_JCOND);
			ctrl.changes_pc      = (alu == rid_pkg::ALU_BCOND || alu == rid_pkg::ALU_JCOND);
		end
	end

endmodule

### rtl/rid_checker.sv
// Port-level checks for the instruction decoder, bound to the top level.
module rid_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [3:0]  alu_op,
	input logic        use_immediate,
	input logic [3:0]  dest_or_cond,
	input logic [3:0]  source_reg,
	input logic [7:0]  immediate_value,
	input logic        reads_memory,
	input logic        writes_memory,
	input logic        writes_register,
	input logic        changes_pc,
	input logic        is_nop,
	input logic        is_illegal
);

	// A stalled result stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(alu_op) &&
		$stable(dest_or_cond) && $stable(source_reg) && $stable(immediate_value))
		else $error("result changed under stall");

	// A NOP carries a clean bundle with zero fields.
	a_nop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_nop |-> !is_illegal && alu_op == rid_pkg::ALU_ADD &&
		!writes_register && !changes_pc && immediate_value == 8'd0 &&
		dest_or_cond == 4'd0)
		else $error("nop bundle not clean");

	// An illegal word has no side effects.
	a_illegal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_illegal |-> alu_op == rid_pkg::ALU_ADD && !use_immediate &&
		!reads_memory && !writes_memory && !writes_register && !changes_pc)
		else $error("illegal word has side effects");

	// Flags agree with the ALU code.
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(reads_memory && writes_memory) &&
		(changes_pc == (alu_op == rid_pkg::ALU_BCOND || alu_op == rid_pkg::ALU_JCOND)) &&
		(!changes_pc || !writes_register) &&
		(!reads_memory || alu_op == rid_pkg::ALU_LOAD) &&
		(writes_memory == (alu_op == rid_pkg::ALU_STOR)))
		else $error("flags disagree with alu code");

endmodule

bind risc_instruction_decoder rid_checker u_rid_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.alu_op          (alu_op),
	.use_immediate   (use_immediate),
	.dest_or_cond    (dest_or_cond),
	.source_reg      (source_reg),
	.immediate_value (immediate_value),
	.reads_memory    (reads_memory),
	.writes_memory   (writes_memory),
	.writes_register (writes_register),
	.changes_pc      (changes_pc),
	.is_nop          (is_nop),
	.is_illegal      (is_illegal)
);
